/* hw/rtl/sam_pkg.sv */
// ----------------------------------------------------------------------------
// sam_pkg
// shared codes, widths and transaction types of the sliding anagram matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sam_pkg;

  localparam int CMD_W    = 2;
  localparam int LETTER_W = 5;
  localparam int IDX_W    = 32;
  localparam logic [IDX_W-1:0] IDX_MAX = 32'hFFFF_FFFF;

  // result queue
  localparam int Q_DEPTH = 3;
  localparam int QCW     = 2;
  localparam int QPW     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_FULL = 2'd1,
    ERR_LATE = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_RAISE,
    OP_LOWER
  } op_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             full;
    logic             fwd;
    err_t             error;
    logic [IDX_W-1:0] start;
  } stage_t;

  typedef struct packed {
    logic             match;
    logic [IDX_W-1:0] start;
    err_t             error;
  } result_t;

endpackage

/* hw/rtl/sam_if.sv */
// ----------------------------------------------------------------------------
// sam_if
// letter and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sam_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [4:0] letter;

  modport source (output valid, output command, output letter, input ready);
  modport sink (input valid, input command, input letter, output ready);
endinterface

interface sam_out_if;
  logic        valid;
  logic        ready;
  logic        match;
  logic [31:0] start_position;
  logic [1:0]  error;

  modport source (output valid, output match, output start_position, output error, input ready);
  modport sink (input valid, input match, input start_position, input error, output ready);
endinterface

/* hw/rtl/sam_ram.sv */
// ----------------------------------------------------------------------------
// sam_ram
// generic ram, one write port, registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 26,
  parameter int READS = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr [READS],
  output logic [WIDTH-1:0] rdata [READS]
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  for (genvar i = 0; i < READS; i++) begin : g_read
    always_ff @(posedge clk) begin
      rdata[i] <= mem[raddr[i]];
    end
  end

endmodule

/* hw/rtl/sam_front.sv */
// ----------------------------------------------------------------------------
// sam_front
// command decode, search counters and window letter ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sam_front #(
  parameter int MAX_PATTERN = 64,
  parameter int ALPHABET = 26,
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1,
  localparam int HW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [sam_pkg::CMD_W-1:0]    command,
  input  logic [sam_pkg::LETTER_W-1:0] letter,
  output logic [AW-1:0]                lookup,
  output sam_pkg::stage_t              stage,
  output logic [AW-1:0]                stage_letter,
  output logic [AW-1:0]                old_letter
);

  import sam_pkg::*;

  localparam int PW = $clog2(MAX_PATTERN + 1);

  logic [HW-1:0]    head, head_next, head_step;
  logic [PW-1:0]    pattern_count, pattern_count_next;
  logic [PW-1:0]    window_fill, window_fill_next;
  logic [IDX_W-1:0] text_index, text_index_next;
  logic             text_started, text_started_next;
  stage_t           stage_next;
  logic             win_we;
  logic [HW-1:0]    win_raddr [1];
  logic [AW-1:0]    win_rdata [1];

  always_comb begin
    if (32'(letter) >= 32'(ALPHABET)) begin
      lookup = AW'(ALPHABET - 1);
    end else begin
      lookup = AW'(letter);
    end
  end

  assign head_step = (PW'(head) == pattern_count - PW'(1)) ? '0 : head + HW'(1);

  always_comb begin
    head_next          = head;
    pattern_count_next = pattern_count;
    window_fill_next   = window_fill;
    text_index_next    = text_index;
    text_started_next  = text_started;
    win_we             = 1'b0;
    stage_next         = '{valid: accept, op: OP_NONE, full: 1'b0, fwd: 1'b0,
                           error: ERR_NONE, start: '0};
    if (accept) begin
      unique case (command)
        CMD_CLEAR: begin
          head_next          = '0;
          pattern_count_next = '0;
          window_fill_next   = '0;
          text_index_next    = '0;
          text_started_next  = 1'b0;
          stage_next.op      = OP_CLEAR;
        end
        CMD_PATTERN: begin
          if (text_started) begin
            stage_next.error = ERR_LATE;
          end else if (32'(pattern_count) >= 32'(MAX_PATTERN)) begin
            stage_next.error = ERR_FULL;
          end else begin
            pattern_count_next = pattern_count + PW'(1);
            stage_next.op      = OP_RAISE;
          end
        end
        CMD_TEXT: begin
          text_started_next = 1'b1;
          if (text_index != IDX_MAX) begin
            text_index_next = text_index + IDX_W'(1);
          end
          if (pattern_count != '0) begin
            win_we    = 1'b1;
            head_next = head_step;
            if (window_fill < pattern_count) begin
              window_fill_next = window_fill + PW'(1);
            end
            stage_next.op    = OP_LOWER;
            stage_next.full  = (window_fill_next == pattern_count);
            stage_next.fwd   = (head_step == head);
            stage_next.start = text_index - IDX_W'(pattern_count - PW'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      pattern_count <= '0;
      window_fill   <= '0;
      text_index    <= '0;
      text_started  <= 1'b0;
      stage.valid   <= 1'b0;
    end else begin
      head          <= head_next;
      pattern_count <= pattern_count_next;
      window_fill   <= window_fill_next;
      text_index    <= text_index_next;
      text_started  <= text_started_next;
      stage         <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    stage_letter <= lookup;
  end

  assign win_raddr[0] = head_step;

  sam_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_PATTERN),
    .READS (1)
  ) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (head),
    .wdata (lookup),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // single-letter window: the oldest letter is the one just written
  assign old_letter = stage.fwd ? stage_letter : win_rdata[0];

endmodule

/* hw/rtl/sam_balance.sv */
// ----------------------------------------------------------------------------
// sam_balance
// letter balances as raise and lower counts in two rams, nonzero tally
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sam_balance #(
  parameter int MAX_PATTERN = 64,
  parameter int ALPHABET = 26,
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1,
  localparam int BW = $clog2(MAX_PATTERN) + 2,
  localparam int TW = $clog2(ALPHABET + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [AW-1:0]    lookup,
  input  sam_pkg::stage_t  stage,
  input  logic [AW-1:0]    stage_letter,
  input  logic [AW-1:0]    old_letter,
  output logic             result_valid,
  output sam_pkg::result_t result
);

  import sam_pkg::*;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] addr;
    logic [BW-1:0] data;
  } wr_t;

  logic [AW-1:0]       raise_raddr [2];
  logic [AW-1:0]       lower_raddr [2];
  logic [BW-1:0]       raise_rdata [2];
  logic [BW-1:0]       lower_rdata [2];
  wr_t                 raise_wr, lower_wr, raise_last, lower_last;
  logic [ALPHABET-1:0] raise_vld, lower_vld;
  logic                evict_valid;
  logic [AW-1:0]       evict_letter;
  logic [TW-1:0]       tally, tally_mid, tally_new;
  logic [BW-1:0]       r1, l1, r2, l2;
  logic                do_clear, do_evict, raise_op, lower_op;
  logic                inc1, dec1, inc2, dec2;
  logic                match;

  assign raise_raddr[0] = lookup;
  assign raise_raddr[1] = old_letter;
  assign lower_raddr[0] = lookup;
  assign lower_raddr[1] = old_letter;

  assign do_clear = stage.valid && (stage.op == OP_CLEAR);
  assign raise_op = stage.valid && (stage.op == OP_RAISE);
  assign lower_op = stage.valid && (stage.op == OP_LOWER);
  assign do_evict = evict_valid && !do_clear;

  // oldest letter leaves the window
  always_comb begin
    r2 = raise_vld[evict_letter] ? raise_rdata[1] : '0;
    if (raise_last.valid && raise_last.addr == evict_letter) begin
      r2 = raise_last.data;
    end
    l2 = lower_vld[evict_letter] ? lower_rdata[1] : '0;
    if (lower_last.valid && lower_last.addr == evict_letter) begin
      l2 = lower_last.data;
    end
    inc2 = do_evict && (r2 == l2);
    dec2 = do_evict && ((r2 + BW'(1)) == l2);
  end

  // pattern letter or new text letter
  always_comb begin
    r1 = raise_vld[stage_letter] ? raise_rdata[0] : '0;
    if (raise_last.valid && raise_last.addr == stage_letter) begin
      r1 = raise_last.data;
    end
    if (do_evict && evict_letter == stage_letter) begin
      r1 = r2 + BW'(1);
    end
    l1 = lower_vld[stage_letter] ? lower_rdata[0] : '0;
    if (lower_last.valid && lower_last.addr == stage_letter) begin
      l1 = lower_last.data;
    end
    inc1 = (raise_op || lower_op) && (r1 == l1);
    dec1 = (raise_op && ((r1 + BW'(1)) == l1)) || (lower_op && (r1 == (l1 + BW'(1))));
  end

  assign tally_mid = tally + TW'(inc2) - TW'(dec2);
  assign tally_new = tally_mid + TW'(inc1) - TW'(dec1);
  assign match     = lower_op && stage.full && (tally_new == '0);

  always_comb begin
    raise_wr.valid = do_evict || raise_op;
    raise_wr.addr  = do_evict ? evict_letter : stage_letter;
    raise_wr.data  = do_evict ? r2 + BW'(1) : r1 + BW'(1);
    lower_wr.valid = lower_op;
    lower_wr.addr  = stage_letter;
    lower_wr.data  = l1 + BW'(1);
  end

  sam_ram #(
    .WIDTH (BW),
    .DEPTH (ALPHABET),
    .READS (2)
  ) u_raise (
    .clk   (clk),
    .we    (raise_wr.valid),
    .waddr (raise_wr.addr),
    .wdata (raise_wr.data),
    .raddr (raise_raddr),
    .rdata (raise_rdata)
  );

  sam_ram #(
    .WIDTH (BW),
    .DEPTH (ALPHABET),
    .READS (2)
  ) u_lower (
    .clk   (clk),
    .we    (lower_wr.valid),
    .waddr (lower_wr.addr),
    .wdata (lower_wr.data),
    .raddr (lower_raddr),
    .rdata (lower_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      evict_valid      <= 1'b0;
      tally            <= '0;
      raise_vld        <= '0;
      lower_vld        <= '0;
      raise_last.valid <= 1'b0;
      lower_last.valid <= 1'b0;
    end else begin
      evict_valid <= lower_op && stage.full;
      raise_last  <= raise_wr;
      lower_last  <= lower_wr;
      if (do_clear) begin
        tally     <= '0;
        raise_vld <= '0;
        lower_vld <= '0;
      end else begin
        tally <= tally_new;
        if (raise_wr.valid) begin
          raise_vld[raise_wr.addr] <= 1'b1;
        end
        if (lower_wr.valid) begin
          lower_vld[lower_wr.addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    evict_letter <= old_letter;
  end

  assign result_valid = stage.valid;
  assign result.match = match;
  assign result.start = match ? stage.start : '0;
  assign result.error = stage.error;

endmodule

/* hw/rtl/sam_outq.sv */
// ----------------------------------------------------------------------------
// sam_outq
// three-entry result queue in front of the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sam_outq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sam_pkg::result_t        push_data,
  output logic [sam_pkg::QCW-1:0] count,
  sam_out_if.source               results
);

  import sam_pkg::*;

  result_t        q [Q_DEPTH];
  logic [QPW-1:0] wr_ptr, rd_ptr;
  logic           pop;

  assign pop                    = results.valid && results.ready;
  assign results.valid          = (count != '0);
  assign results.match          = q[rd_ptr].match;
  assign results.start_position = q[rd_ptr].start;
  assign results.error          = q[rd_ptr].error;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

endmodule

/* hw/rtl/sliding_anagram_matcher_top.sv */
// ----------------------------------------------------------------------------
// sliding_anagram_matcher_top
// path: stage register, then result queue, then the result channel
// throughput: one transaction per cycle while the result queue has room, set
// by one write per balance ram and a registered window letter for eviction
// reset: rst clears counters, tally and balance valid bits; ready next cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_anagram_matcher_top #(
  parameter int MAX_PATTERN = 64,
  parameter int ALPHABET = 26
) (
  input  logic      clk,
  input  logic      rst,
  sam_in_if.sink    letters,
  sam_out_if.source results
);

  import sam_pkg::*;

  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int RW = QCW + 1;

  logic          accept;
  logic [AW-1:0] lookup, stage_letter, old_letter;
  stage_t        stage;
  logic          result_valid;
  result_t       result;
  logic [QCW-1:0] q_count;

  assign accept        = letters.valid && letters.ready;
  assign letters.ready = ({1'b0, q_count} + RW'(stage.valid)) < RW'(Q_DEPTH);

  sam_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (letters.command),
    .letter       (letters.letter),
    .lookup       (lookup),
    .stage        (stage),
    .stage_letter (stage_letter),
    .old_letter   (old_letter)
  );

  sam_balance #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_balance (
    .clk          (clk),
    .rst          (rst),
    .lookup       (lookup),
    .stage        (stage),
    .stage_letter (stage_letter),
    .old_letter   (old_letter),
    .result_valid (result_valid),
    .result       (result)
  );

  sam_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .count     (q_count),
    .results   (results)
  );

endmodule

/* hw/rtl/sam_checker.sv */
// ----------------------------------------------------------------------------
// sam_checker
// port-level checks of the anagram matcher, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sam_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_match,
  input logic [31:0] out_start,
  input logic [1:0]  out_error
);

  import sam_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_match) && $stable(out_start) && $stable(out_error))
    else $error("result payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not empty and ready after reset");

  a_nomatch_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_match |-> out_start == '0)
    else $error("start position without a match");

  a_match_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_match |-> out_error == ERR_NONE)
    else $error("match reported together with an error");

endmodule

bind sliding_anagram_matcher_top sam_checker u_sam_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (letters.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_match (results.match),
  .out_start (results.start_position),
  .out_error (results.error)
);
